>>> hw/rtl/mlpd_pkg.sv
package mlpd_pkg;

   localparam int BYTE_W    = 8;
   localparam int LENGTH_W  = 32;
   localparam int STATUS_W  = 2;
   localparam int LEN_CNT_W = 2;
   localparam int MARKER_MAX = 64;

   // Built-in frame marker, oldest byte first; unused tail entries are zero.
   localparam logic [BYTE_W-1:0] MARKER_BYTES [MARKER_MAX] = '{
      8'h51, 8'h43, 8'h4F, 8'h4E, 8'h46, 8'h5F, 8'h43, 8'h4F,
      8'h4E, 8'h46, 8'h49, 8'h47, 8'h57, 8'h49, 8'h4E, 8'h5F,
      8'h42, 8'h4C, 8'h4F, 8'h43, 8'h4B, 8'h53, 8'h49, 8'h47,
      8'h5F, 8'h36, 8'h38, 8'h62, 8'h37, 8'h65, 8'h37, 8'h64,
      8'h37, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   typedef enum logic [1:0] {
      PH_SEARCH  = 2'd0,
      PH_LENGTH  = 2'd1,
      PH_PAYLOAD = 2'd2,
      PH_DONE    = 2'd3
   } phase_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_PAYLOAD   = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_NO_MARKER = 2'd2,
      ST_TRUNCATED = 2'd3
   } status_type;

   // One accepted input word as seen by the frame control.
   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] in_byte;
      logic              stream_end;
   } step_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   out_byte;
      logic                out_last;
      status_type          out_status;
      logic [LENGTH_W-1:0] out_length;
   } rsp_word_type;

endpackage

>>> hw/rtl/mlpd_req_if.sv
interface mlpd_req_if;
   import mlpd_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              stream_end;

   modport source (output valid, output in_byte, output stream_end, input ready);
   modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

>>> hw/rtl/mlpd_rsp_if.sv
interface mlpd_rsp_if;
   import mlpd_pkg::*;

   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   out_byte;
   logic                out_last;
   logic [STATUS_W-1:0] out_status;
   logic [LENGTH_W-1:0] out_length;

   modport source (output valid, output out_byte, output out_last, output out_status,
                   output out_length, input ready);
   modport sink   (input valid, input out_byte, input out_last, input out_status,
                   input out_length, output ready);
endinterface

>>> hw/rtl/mlpd_window.sv
module mlpd_window #(
   parameter int SIG_LEN = 33
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       shift,
   input  logic                       clear,
   input  logic [mlpd_pkg::BYTE_W-1:0] in_byte,
   output logic                       match
);
   import mlpd_pkg::*;

   logic [BYTE_W-1:0] win_ff   [SIG_LEN];
   logic [BYTE_W-1:0] next_win [SIG_LEN];
   logic [SIG_LEN-1:0] hit;

   // match looks at the window as it stands once in_byte has been shifted in
   for (genvar i = 0; i < SIG_LEN; i++) begin : g_tap
      if (i == SIG_LEN - 1) begin : g_head
         assign next_win[i] = in_byte;
      end else begin : g_body
         assign next_win[i] = win_ff[i+1];
      end
      assign hit[i] = (next_win[i] == MARKER_BYTES[i]);
   end

   assign match = &hit;

   always_ff @(posedge clock) begin
      for (int i = 0; i < SIG_LEN; i++) begin
         if (reset || clear) begin
            win_ff[i] <= '0;
         end else if (shift) begin
            win_ff[i] <= next_win[i];
         end
      end
   end

endmodule

>>> hw/rtl/mlpd_ctrl.sv
module mlpd_ctrl #(
   parameter int LEN_BYTES = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mlpd_pkg::step_type     step,
   input  logic                   match,
   output logic                   res_valid,
   output mlpd_pkg::rsp_word_type res_word
);
   import mlpd_pkg::*;

   localparam logic [LEN_CNT_W:0] LEN_LAST = (LEN_CNT_W+1)'(LEN_BYTES);

   phase_type             phase_ff,    phase_in;
   logic [LEN_CNT_W-1:0]  len_seen_ff, len_seen_in;
   logic [LENGTH_W-1:0]   pay_len_ff,  pay_len_in;
   logic [LENGTH_W-1:0]   remain_ff,   remain_in;
   logic [LENGTH_W-1:0]   len_shifted;
   logic                  len_done;

   assign len_shifted = {pay_len_ff[LENGTH_W-BYTE_W-1:0], step.in_byte};
   assign len_done    = ({1'b0, len_seen_ff} + (LEN_CNT_W+1)'(1)) >= LEN_LAST;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_SEARCH;
         len_seen_ff <= '0;
         pay_len_ff  <= '0;
         remain_ff   <= '0;
      end else begin
         phase_ff    <= phase_in;
         len_seen_ff <= len_seen_in;
         pay_len_ff  <= pay_len_in;
         remain_ff   <= remain_in;
      end
   end

   always_comb begin
      phase_in            = phase_ff;
      len_seen_in         = len_seen_ff;
      pay_len_in          = pay_len_ff;
      remain_in           = remain_ff;
      res_valid           = 1'b0;
      res_word.out_byte   = '0;
      res_word.out_last   = 1'b0;
      res_word.out_status = ST_PAYLOAD;
      res_word.out_length = '0;

      if (step.valid) begin
         case (phase_ff)
            PH_SEARCH: begin
               if (match) begin
                  phase_in    = PH_LENGTH;
                  len_seen_in = '0;
                  pay_len_in  = '0;
                  if (step.stream_end) begin
                     res_valid           = 1'b1;
                     res_word.out_last   = 1'b1;
                     res_word.out_status = ST_TRUNCATED;
                  end
               end else if (step.stream_end) begin
                  res_valid           = 1'b1;
                  res_word.out_last   = 1'b1;
                  res_word.out_status = ST_NO_MARKER;
               end
            end
            PH_LENGTH: begin
               pay_len_in = len_shifted;
               if (len_done) begin
                  if (len_shifted == '0) begin
                     res_valid           = 1'b1;
                     res_word.out_last   = 1'b1;
                     res_word.out_status = ST_EMPTY;
                     phase_in            = PH_DONE;
                  end else if (step.stream_end) begin
                     res_valid           = 1'b1;
                     res_word.out_last   = 1'b1;
                     res_word.out_status = ST_TRUNCATED;
                     res_word.out_length = len_shifted;
                  end else begin
                     phase_in  = PH_PAYLOAD;
                     remain_in = len_shifted;
                  end
               end else begin
                  len_seen_in = len_seen_ff + LEN_CNT_W'(1);
                  if (step.stream_end) begin
                     res_valid           = 1'b1;
                     res_word.out_last   = 1'b1;
                     res_word.out_status = ST_TRUNCATED;
                  end
               end
            end
            PH_PAYLOAD: begin
               res_valid           = 1'b1;
               res_word.out_length = pay_len_ff;
               if (remain_ff <= LENGTH_W'(1)) begin
                  res_word.out_byte = step.in_byte;
                  res_word.out_last = 1'b1;
                  remain_in         = '0;
                  phase_in          = PH_DONE;
               end else if (step.stream_end) begin
                  // stream cut short: the byte is dropped
                  res_word.out_last   = 1'b1;
                  res_word.out_status = ST_TRUNCATED;
               end else begin
                  res_word.out_byte = step.in_byte;
                  remain_in         = remain_ff - LENGTH_W'(1);
               end
            end
            PH_DONE: begin
            end
            default: begin
            end
         endcase

         // end of stream puts everything back to its reset value
         if (step.stream_end) begin
            phase_in    = PH_SEARCH;
            len_seen_in = '0;
            pay_len_in  = '0;
            remain_in   = '0;
         end
      end
   end

   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      step.valid && step.stream_end |=> phase_ff == PH_SEARCH && len_seen_ff == '0)
      else $error("stream end did not return control to search");

   a_payload_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> remain_ff != '0)
      else $error("payload phase with nothing left to pass");

   a_empty_len: assert property (@(posedge clock) disable iff (reset)
      res_valid && res_word.out_status == ST_EMPTY |-> res_word.out_length == '0)
      else $error("empty payload reported with nonzero length");

endmodule

>>> hw/rtl/marker_length_prefixed_deframer_unit.sv
// Marker / length-prefixed deframer. Scans a byte stream one word per cycle
// and compares the last SIG_LEN bytes against the built-in frame marker.
// After the first hit the next LEN_BYTES bytes are a big-endian payload
// length; exactly that many payload bytes go out with out_status 0, the
// final one flagged by out_last. An empty payload, a missing marker, or a
// stream that ends inside the length or payload each give one status word
// with out_last set. After a finished frame input is swallowed until the
// word carrying stream_end, which always restarts the scan. It takes one
// input word per cycle unless stalled; a result appears on rsp in the
// cycle after the input word is taken. The single output register is the
// only stall: req_if.ready drops only while it holds a result rsp has not taken.
module marker_length_prefixed_deframer_unit #(
   parameter int SIG_LEN   = 33,
   parameter int LEN_BYTES = 4
) (
   input  logic              clock,
   input  logic              reset,
   mlpd_req_if.sink          req_if,
   mlpd_rsp_if.source        rsp_if
);
   import mlpd_pkg::*;

   logic         accept;
   logic         match;
   step_type     step;
   logic         res_valid;
   rsp_word_type res_word;

   // output register: the result waiting for the rsp side
   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_word_ff,  out_word_in;

   // take a new word whenever the output register is free or draining now
   assign req_if.ready = !out_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   assign step.valid      = accept;
   assign step.in_byte    = req_if.in_byte;
   assign step.stream_end = req_if.stream_end;

   // window only matters while searching; the stream end clears it, so it
   // can shift on every accepted word
   mlpd_window #(
      .SIG_LEN (SIG_LEN)
   ) u_window (
      .clock   (clock),
      .reset   (reset),
      .shift   (accept),
      .clear   (accept && req_if.stream_end),
      .in_byte (req_if.in_byte),
      .match   (match)
   );

   mlpd_ctrl #(
      .LEN_BYTES (LEN_BYTES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .match     (match),
      .res_valid (res_valid),
      .res_word  (res_word)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      if (accept) begin
         out_valid_in = res_valid;
         if (res_valid) begin
            out_word_in = res_word;
         end
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      out_word_ff <= out_word_in;
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.out_byte   = out_word_ff.out_byte;
   assign rsp_if.out_last   = out_word_ff.out_last;
   assign rsp_if.out_status = out_word_ff.out_status;
   assign rsp_if.out_length = out_word_ff.out_length;

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_word_ff.out_status != ST_PAYLOAD |-> out_word_ff.out_last)
      else $error("status word without out_last");

   a_status_byte: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_word_ff.out_status != ST_PAYLOAD |-> out_word_ff.out_byte == '0)
      else $error("status word carries a data byte");

   a_drain_only: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(out_valid_ff) |-> $past(rsp_if.ready))
      else $error("result dropped without being taken");

endmodule

>>> test/mlpd_output_monitor.sv
`timescale 1ns / 100ps

module mlpd_output_monitor #(
   parameter int SIG_LEN   = 33,
   parameter int LEN_BYTES = 4
) (
   input  logic clock,
   input  logic reset,
   mlpd_req_if  req,
   mlpd_rsp_if  rsp,
   output int   mismatches,
   output int   words_outstanding
);
   import mlpd_pkg::*;

   // deframer state, mirrored
   logic [BYTE_W-1:0]    recent_bytes [SIG_LEN];
   phase_type            scan_phase;
   logic [LEN_CNT_W-1:0] len_bytes_seen;
   logic [LENGTH_W-1:0]  frame_length;
   logic [LENGTH_W-1:0]  bytes_left;

   rsp_word_type deframed_due [$];
   rsp_word_type want;

   function automatic void clear_scan();
      for (int i = 0; i < SIG_LEN; i++) recent_bytes[i] = '0;
      scan_phase     = PH_SEARCH;
      len_bytes_seen = '0;
      frame_length   = '0;
      bytes_left     = '0;
   endfunction

   function automatic void owe_word(input logic [BYTE_W-1:0] b, input logic last,
                                    input status_type st, input logic [LENGTH_W-1:0] len);
      rsp_word_type w;
      w.out_byte   = b;
      w.out_last   = last;
      w.out_status = st;
      w.out_length = len;
      deframed_due.push_back(w);
   endfunction

   function automatic void deframe_byte(input logic [BYTE_W-1:0] b, input logic fin);
      logic hit;
      hit = 1'b1;
      case (scan_phase)
         PH_SEARCH: begin
            for (int i = 0; i < SIG_LEN - 1; i++) recent_bytes[i] = recent_bytes[i+1];
            recent_bytes[SIG_LEN-1] = b;
            for (int i = 0; i < SIG_LEN; i++)
               if (recent_bytes[i] != MARKER_BYTES[i]) hit = 1'b0;
            if (hit) begin
               scan_phase     = PH_LENGTH;
               len_bytes_seen = '0;
               frame_length   = '0;
               if (fin) owe_word('0, 1'b1, ST_TRUNCATED, '0);
            end else if (fin) begin
               owe_word('0, 1'b1, ST_NO_MARKER, '0);
            end
         end
         PH_LENGTH: begin
            frame_length = {frame_length[LENGTH_W-BYTE_W-1:0], b};
            if (int'(len_bytes_seen) + 1 >= LEN_BYTES) begin
               if (frame_length == '0) begin
                  owe_word('0, 1'b1, ST_EMPTY, '0);
                  scan_phase = PH_DONE;
               end else if (fin) begin
                  owe_word('0, 1'b1, ST_TRUNCATED, frame_length);
               end else begin
                  scan_phase = PH_PAYLOAD;
                  bytes_left = frame_length;
               end
            end else begin
               len_bytes_seen = len_bytes_seen + 1'b1;
               if (fin) owe_word('0, 1'b1, ST_TRUNCATED, '0);
            end
         end
         PH_PAYLOAD: begin
            if (bytes_left <= 1) begin
               owe_word(b, 1'b1, ST_PAYLOAD, frame_length);
               bytes_left = '0;
               scan_phase = PH_DONE;
            end else if (fin) begin
               owe_word('0, 1'b1, ST_TRUNCATED, frame_length);
            end else begin
               owe_word(b, 1'b0, ST_PAYLOAD, frame_length);
               bytes_left = bytes_left - 1'b1;
            end
         end
         default: ;
      endcase
      if (fin) clear_scan();
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_scan();
         deframed_due.delete();
         mismatches = 0;
      end else begin
         if (req.valid && req.ready) deframe_byte(req.in_byte, req.stream_end);
         if (rsp.valid && rsp.ready) begin
            if (deframed_due.size() == 0) begin
               $error("result word with nothing outstanding");
               mismatches++;
            end else begin
               want = deframed_due.pop_front();
               if (rsp.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %0h, got %0h", want.out_byte, rsp.out_byte);
                  mismatches++;
               end
               if (rsp.out_last !== want.out_last) begin
                  $error("out_last: expected %0d, got %0d", want.out_last, rsp.out_last);
                  mismatches++;
               end
               if (rsp.out_status !== want.out_status) begin
                  $error("out_status: expected %0d, got %0d", want.out_status,
                         rsp.out_status);
                  mismatches++;
               end
               if (rsp.out_length !== want.out_length) begin
                  $error("out_length: expected %0h, got %0h", want.out_length,
                         rsp.out_length);
                  mismatches++;
               end
            end
         end
      end
      words_outstanding <= deframed_due.size();
   end

endmodule

>>> test/marker_length_prefixed_deframer_unit_tb.sv
`timescale 1ns / 100ps

module marker_length_prefixed_deframer_unit_tb;
   import mlpd_pkg::*;

   localparam int SIG_LEN   = 33;
   localparam int LEN_BYTES = 4;
   localparam int PHASE_WORDS = 375;   // random words per idling phase

   logic clock = 1'b0;
   logic reset = 1'b1;

   int send_idle_pct;   // chance per cycle that the sender holds back
   int stall_pct;       // chance per cycle that the receiver stalls
   int words_sent;
   int base_count;
   int mismatches;
   int words_outstanding;

   mlpd_req_if req_ch ();
   mlpd_rsp_if rsp_ch ();

   marker_length_prefixed_deframer_unit #(
      .SIG_LEN   (SIG_LEN),
      .LEN_BYTES (LEN_BYTES)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // Passive side: predicts every result word and compares.
   mlpd_output_monitor #(
      .SIG_LEN   (SIG_LEN),
      .LEN_BYTES (LEN_BYTES)
   ) u_monitor (
      .clock             (clock),
      .reset             (reset),
      .req               (req_ch),
      .rsp               (rsp_ch),
      .mismatches        (mismatches),
      .words_outstanding (words_outstanding)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Receiver: random back-pressure, redrawn every cycle.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // One word on req. Idle cycles are drawn before the word goes up; valid
   // stays high back to back when no gap is drawn. Returns on the edge that
   // takes the word.
   task automatic send_word(input logic [BYTE_W-1:0] b, input logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.in_byte    <= b;
      req_ch.stream_end <= fin;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      words_sent++;
   endtask

   // Random bytes; the last one optionally closes the stream.
   task automatic send_noise(input int n, input logic end_at_last);
      for (int i = 0; i < n; i++)
         send_word(8'($urandom_range(255)), end_at_last && (i == n - 1));
   endtask

   task automatic send_marker(input logic end_at_last);
      for (int i = 0; i < SIG_LEN; i++)
         send_word(MARKER_BYTES[i], end_at_last && (i == SIG_LEN - 1));
   endtask

   // First n bytes of the big-endian length field.
   task automatic send_length(input logic [LENGTH_W-1:0] len, input int n,
                              input logic end_at_last);
      for (int i = 0; i < n; i++)
         send_word(len[BYTE_W*(LEN_BYTES-1-i) +: BYTE_W], end_at_last && (i == n - 1));
   endtask

   // Hold the sender until every predicted word has come out.
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (words_outstanding != 0) @(posedge clock);
   endtask

   // One random stream. Mostly a well-formed frame with random content;
   // the rest are missing markers, broken markers and early stream ends.
   task automatic send_random_stream();
      int kind;
      int pick;
      int m;
      logic [LENGTH_W-1:0] len;
      kind = $urandom_range(99);
      send_noise($urandom_range(0, 6), 1'b0);
      // partial marker followed by a stray byte
      if ($urandom_range(3) == 0) begin
         m = $urandom_range(1, SIG_LEN - 1);
         for (int i = 0; i < m; i++) send_word(MARKER_BYTES[i], 1'b0);
         send_noise(1, 1'b0);
      end
      if (kind < 6) begin
         send_noise($urandom_range(1, 8), 1'b1);   // marker never shows
         return;
      end
      if (kind < 11) begin
         send_marker(1'b1);                        // marker on the final byte
         return;
      end
      send_marker(1'b0);
      pick = $urandom_range(99);
      if (pick < 10)      len = '0;
      else if (pick < 30) len = $urandom;          // exercises every length bit
      else                len = $urandom_range(1, 20);
      if (kind < 17) begin
         send_length(len, $urandom_range(1, LEN_BYTES - 1), 1'b1);   // ends in length
         return;
      end
      if (kind < 23) begin
         send_length(len, LEN_BYTES, 1'b1);        // length done on final byte
         return;
      end
      send_length(len, LEN_BYTES, 1'b0);
      if (len == 0) begin
         send_noise($urandom_range(1, 5), 1'b1);   // swallowed tail
         return;
      end
      if (len > 64) begin
         send_noise($urandom_range(1, 8), 1'b1);   // huge frame, cut short
         return;
      end
      if (kind < 35 && len > 1) begin
         send_noise($urandom_range(1, int'(len) - 1), 1'b1);   // cut inside payload
         return;
      end
      if (kind < 55) begin
         send_noise(int'(len), 1'b1);              // end on last payload byte
         return;
      end
      send_noise(int'(len), 1'b0);
      send_noise($urandom_range(1, 5), 1'b1);
   endtask

   initial begin
      req_ch.valid      = 1'b0;
      req_ch.in_byte    = '0;
      req_ch.stream_end = 1'b0;
      send_idle_pct     = 0;
      stall_pct         = 0;
      words_sent        = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // --- directed streams ---
      send_word(8'hFF, 1'b1);                      // no marker, all ones
      send_word(8'h00, 1'b1);                      // no marker, all zeros
      send_marker(1'b1);                           // marker on the final byte
      send_marker(1'b0);                           // empty payload, tail ignored
      send_length('0, LEN_BYTES, 1'b0);
      send_noise(2, 1'b1);
      send_marker(1'b0);                           // empty payload on final byte
      send_length('0, LEN_BYTES, 1'b1);
      send_marker(1'b0);                           // one byte, ends on it
      send_length(32'd1, LEN_BYTES, 1'b0);
      send_word(8'hFF, 1'b1);
      send_marker(1'b0);                           // full length on final byte
      send_length(32'hFFFF_FFFF, LEN_BYTES, 1'b1);
      send_marker(1'b0);                           // ends inside the length
      send_length(32'h1234_5678, 2, 1'b1);
      send_marker(1'b0);                           // ends inside the payload
      send_length(32'd3, LEN_BYTES, 1'b0);
      send_word(8'hAA, 1'b0);
      send_word(8'h55, 1'b1);
      send_marker(1'b0);                           // normal frame, ignored tail
      send_length(32'd2, LEN_BYTES, 1'b0);
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(8'h00, 1'b1);

      // sender waits for the block to empty out
      drain();

      // --- random streams over the idling phases ---
      base_count = words_sent;
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 77; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 77; end
            default: begin send_idle_pct = 21; stall_pct = 21; end
         endcase
         while (words_sent < base_count + (p + 1) * PHASE_WORDS) send_random_stream();
      end

      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && words_outstanding == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/mlpd_pkg.sv
hw/rtl/mlpd_req_if.sv
hw/rtl/mlpd_rsp_if.sv
hw/rtl/mlpd_window.sv
hw/rtl/mlpd_ctrl.sv
hw/rtl/marker_length_prefixed_deframer_unit.sv
test/mlpd_output_monitor.sv
test/marker_length_prefixed_deframer_unit_tb.sv
